// ----- sv/lsf_pkg.sv -----
// Package for the Laplacian sketch filter: register codes, field widths, reset values,
// divide reciprocals and the default line length. No dependencies.
package lsf_pkg;

	localparam int DEF_MAX_WIDTH = 1024;

	localparam int COL_W      = 11;
	localparam int ROW_W      = 17;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH     = 3'd0,
		REG_FRAME_HEIGHT    = 3'd1,
		REG_NOISE_THRESHOLD = 3'd2,
		REG_EDGE_GAIN       = 3'd3,
		REG_LOW_CUT         = 3'd4
	} cfg_reg_t;

	localparam logic [10:0] RST_FRAME_WIDTH     = 11'd640;
	localparam logic [15:0] RST_FRAME_HEIGHT    = 16'd480;
	localparam logic [10:0] RST_NOISE_THRESHOLD = 11'd25;
	localparam logic [3:0]  RST_EDGE_GAIN       = 4'd2;
	localparam logic [7:0]  RST_LOW_CUT         = 8'd32;

	// Reciprocals for the divide by 3 (gray) and by 12 (blur).
	localparam logic [9:0]  RECIP3  = 10'd683;
	localparam int          SHIFT3  = 11;
	localparam logic [11:0] RECIP12 = 12'd2731;
	localparam int          SHIFT12 = 15;

endpackage

// ----- sv/lsf_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module lsf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- sv/laplacian_sketch_filter.sv -----
// Laplacian pencil-sketch filter with a 3x3 blur over a raster RGB stream.
// Depends on lsf_pkg and lsf_ram.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_ready  | red, green, blue, pad
//   out     | output    | out_valid / out_ready| out_red, out_green, out_blue, frame_last
//   cfg     | input     | cfg_write            | cfg_index, cfg_data
//
// One request is taken per clock unless the output stalls; each result is registered in
// stages 1, 2 and 3 and at the output. The rate holds as the gray, sketch and color
// memories are dual-port, each read once and written once per request in consecutive stages.
// Reset clears position, valid bits, windows and config registers; memories are not cleared.
// A stalled output freezes the whole pipeline, memory read registers included.
module laplacian_sketch_filter
	import lsf_pkg::*;
#(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            red,
	input  logic [7:0]            green,
	input  logic [7:0]            blue,
	input  logic                  pad,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [7:0]            out_red,
	output logic [7:0]            out_green,
	output logic [7:0]            out_blue,
	output logic                  frame_last,
	input  logic                  cfg_write,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int AW    = $clog2(MAX_WIDTH);
	localparam int CDEP  = 2 * MAX_WIDTH + 2;
	localparam int CAW   = $clog2(CDEP);

	// Configuration registers.
	logic [10:0] frame_width_q;
	logic [15:0] frame_height_q;
	logic [10:0] noise_threshold_q;
	logic [3:0]  edge_gain_q;
	logic [7:0]  low_cut_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q     <= RST_FRAME_WIDTH;
			frame_height_q    <= RST_FRAME_HEIGHT;
			noise_threshold_q <= RST_NOISE_THRESHOLD;
			edge_gain_q       <= RST_EDGE_GAIN;
			low_cut_q         <= RST_LOW_CUT;
		end else if (cfg_write) begin
			case (cfg_reg_t'(cfg_index))
				REG_FRAME_WIDTH:     frame_width_q     <= cfg_data[10:0];
				REG_FRAME_HEIGHT:    frame_height_q    <= cfg_data[15:0];
				REG_NOISE_THRESHOLD: noise_threshold_q <= cfg_data[10:0];
				REG_EDGE_GAIN:       edge_gain_q       <= cfg_data[3:0];
				REG_LOW_CUT:         low_cut_q         <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	// Effective geometry.
	logic [COL_W-1:0] wid;
	logic [15:0]      hgt;
	logic [ROW_W-1:0] hgt_x;
	logic [CAW:0]     len;

	always_comb begin
		if (frame_width_q < 11'd3) begin
			wid = 11'd3;
		end else if (int'(frame_width_q) > MAX_WIDTH) begin
			wid = COL_W'(MAX_WIDTH);
		end else begin
			wid = frame_width_q;
		end
		hgt   = (frame_height_q < 16'd3) ? 16'd3 : frame_height_q;
		hgt_x = {1'b0, hgt};
		len   = (CAW+1)'({wid, 1'b0}) + (CAW+1)'(2);
	end

	// Pipeline control.
	logic advance;
	logic accept;
	logic out_valid_q;

	assign advance  = !out_valid_q || out_ready;
	assign in_ready = advance;
	assign accept   = in_valid && advance;

	// Stage 0: position of the incoming request.
	logic [COL_W-1:0] col_q;
	logic [ROW_W-1:0] row_q;
	logic [CAW-1:0]   cidx_q;
	logic             primed_q;

	logic [COL_W-1:0] c0;
	logic [ROW_W-1:0] r0;
	logic [COL_W-1:0] col_n;
	logic [ROW_W-1:0] row_n;
	logic             start0;
	logic [CAW-1:0]   cidx0;
	logic             wrap0;
	logic             emit0;
	logic             zero0;
	logic [7:0]       rr0;
	logic [7:0]       gg0;
	logic [7:0]       bb0;
	logic [9:0]       sum0;
	logic [19:0]      gprod0;
	logic             inner1_0;
	logic             inner2_0;
	logic             last0;
	logic [COL_W-1:0] mc0;

	always_comb begin
		c0 = col_q;
		r0 = row_q;
		if (c0 >= wid) begin
			c0 = '0;
			r0 = r0 + ROW_W'(1);
		end
		if (r0 > hgt_x + ROW_W'(2) || (r0 == hgt_x + ROW_W'(2) && c0 >= COL_W'(2))) begin
			c0 = '0;
			r0 = '0;
		end
		if (c0 + COL_W'(1) >= wid) begin
			col_n = '0;
			row_n = r0 + ROW_W'(1);
		end else begin
			col_n = c0 + COL_W'(1);
			row_n = r0;
		end
		if (row_n == hgt_x + ROW_W'(2) && col_n >= COL_W'(2)) begin
			col_n = '0;
			row_n = '0;
		end

		// Color delay index runs modulo 2W+2 from the frame start.
		start0 = (c0 == '0) && (r0 == '0);
		cidx0  = start0 ? '0 : cidx_q;
		wrap0  = ((CAW+1)'(cidx0) + (CAW+1)'(1)) == len;
		emit0  = start0 ? 1'b0 : primed_q;

		zero0 = pad || (r0 >= hgt_x);
		rr0   = zero0 ? 8'd0 : red;
		gg0   = zero0 ? 8'd0 : green;
		bb0   = zero0 ? 8'd0 : blue;
		sum0  = 10'(rr0) + 10'(gg0) + 10'(bb0);
		gprod0 = 20'(sum0) * 20'(RECIP3);

		inner1_0 = (c0 >= COL_W'(2)) && (r0 >= ROW_W'(2)) && (r0 <= hgt_x - ROW_W'(1));
		if (c0 != '0) begin
			mc0      = c0 - COL_W'(1);
			inner2_0 = (mc0 >= COL_W'(2)) && (r0 >= ROW_W'(3)) && (r0 <= hgt_x);
		end else begin
			mc0      = wid - COL_W'(1);
			inner2_0 = (mc0 >= COL_W'(2)) && (r0 >= ROW_W'(4)) && (r0 <= hgt_x + ROW_W'(1));
		end
		// The last output pixel is delivered by the second flush request of the last row.
		last0 = (c0 == COL_W'(1)) && (r0 == hgt_x + ROW_W'(2));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			cidx_q   <= '0;
			primed_q <= 1'b0;
		end else if (accept) begin
			col_q    <= col_n;
			row_q    <= row_n;
			cidx_q   <= wrap0 ? '0 : cidx0 + CAW'(1);
			primed_q <= emit0 || wrap0;
		end
	end

	// Memories.
	logic [15:0] gray_rd;
	logic [15:0] sk_rd;
	logic [23:0] color_rd;

	logic            v_s1;
	logic [7:0]      g_s1;
	logic [23:0]     rgb_s1;
	logic            inner1_s1;
	logic            inner2_s1;
	logic            last_s1;
	logic            emit_s1;
	logic [CAW-1:0]  cidx_s1;
	logic [AW-1:0]   ga_s1;
	logic [AW-1:0]   sa_s1;

	logic            v_s2;
	logic [7:0]      mv_s2;
	logic            inner2_s2;
	logic            last_s2;
	logic            emit_s2;
	logic [AW-1:0]   sa_s2;
	logic [23:0]     old_s2;

	lsf_ram #(.WIDTH(16), .DEPTH(MAX_WIDTH)) u_gray_ram (
		.clk   (clk),
		.we    (v_s1 && advance),
		.waddr (ga_s1),
		.wdata ({gray_rd[7:0], g_s1}),
		.re    (advance),
		.raddr (AW'(c0)),
		.rdata (gray_rd)
	);

	lsf_ram #(.WIDTH(16), .DEPTH(MAX_WIDTH)) u_sketch_ram (
		.clk   (clk),
		.we    (v_s2 && advance),
		.waddr (sa_s2),
		.wdata ({sk_rd[7:0], mv_s2}),
		.re    (advance),
		.raddr (sa_s1),
		.rdata (sk_rd)
	);

	lsf_ram #(.WIDTH(24), .DEPTH(CDEP)) u_color_ram (
		.clk   (clk),
		.we    (v_s1 && advance),
		.waddr (cidx_s1),
		.wdata (rgb_s1),
		.re    (advance),
		.raddr (cidx0),
		.rdata (color_rd)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (advance) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			g_s1      <= gprod0[SHIFT3+7:SHIFT3];
			rgb_s1    <= {rr0, gg0, bb0};
			inner1_s1 <= inner1_0;
			inner2_s1 <= inner2_0;
			last_s1   <= last0;
			emit_s1   <= emit0;
			cidx_s1   <= cidx0;
			ga_s1     <= AW'(c0);
			sa_s1     <= AW'(mc0);
		end
	end

	// Stage 1: Laplacian and noise tests over the gray window.
	logic [7:0] gwin_q [6];

	logic signed [12:0] gw [6];
	logic signed [12:0] gc [3];
	logic signed [12:0] lap1;
	logic signed [12:0] t1;
	logic signed [12:0] t2;
	logic signed [12:0] tmax1;
	logic signed [17:0] scaled1;
	logic [7:0]         v1;
	logic [7:0]         mv1;

	always_comb begin
		for (int i = 0; i < 6; i++) begin
			gw[i] = $signed({5'b0, gwin_q[i]});
		end
		gc[0] = $signed({5'b0, gray_rd[15:8]});
		gc[1] = $signed({5'b0, gray_rd[7:0]});
		gc[2] = $signed({5'b0, g_s1});

		lap1 = gw[0] + gw[1] + gw[2] + gw[3] + gw[5] + gc[0] + gc[1] + gc[2]
		     - (gw[4] <<< 3);
		t1 = gw[0] + gw[3] - gc[0] + gw[1] - gc[1] + gw[2] - gw[5] - gc[2];
		t2 = gw[0] + gw[3] + gc[0] - gw[1] + gc[1] - gw[2] - gw[5] - gc[2];
		if (t1 < 0) begin
			t1 = -t1;
		end
		if (t2 < 0) begin
			t2 = -t2;
		end
		tmax1   = (t1 < t2) ? t2 : t1;
		scaled1 = 18'(lap1) * $signed({14'b0, edge_gain_q});

		if (tmax1 < $signed({2'b0, noise_threshold_q})) begin
			v1 = 8'd0;
		end else if (scaled1 > 18'sd255) begin
			v1 = 8'd255;
		end else if (scaled1 < 18'sd0 || scaled1 < $signed({10'b0, low_cut_q})) begin
			v1 = 8'd0;
		end else begin
			v1 = scaled1[7:0];
		end
		mv1 = inner1_s1 ? (8'd255 - v1) : gwin_q[4];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				gwin_q[i] <= 8'd0;
			end
			v_s2 <= 1'b0;
		end else if (advance) begin
			v_s2 <= v_s1;
			if (v_s1) begin
				gwin_q[0] <= gwin_q[3];
				gwin_q[1] <= gwin_q[4];
				gwin_q[2] <= gwin_q[5];
				gwin_q[3] <= gray_rd[15:8];
				gwin_q[4] <= gray_rd[7:0];
				gwin_q[5] <= g_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			mv_s2     <= mv1;
			inner2_s2 <= inner2_s1;
			last_s2   <= last_s1;
			emit_s2   <= emit_s1;
			sa_s2     <= sa_s1;
			old_s2    <= color_rd;
		end
	end

	// Stage 2: blur sum over the sketch window.
	logic [7:0]  swin_q [6];
	logic [11:0] bsum2;

	logic        v_s3;
	logic [11:0] bsum_s3;
	logic        inner2_s3;
	logic        last_s3;
	logic        emit_s3;
	logic [23:0] old_s3;

	always_comb begin
		bsum2 = 12'(swin_q[0]) + 12'(swin_q[1]) + 12'(swin_q[2]) + 12'(swin_q[3])
		      + {2'b0, swin_q[4], 2'b0} + 12'(swin_q[5])
		      + 12'(sk_rd[15:8]) + 12'(sk_rd[7:0]) + 12'(mv_s2);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				swin_q[i] <= 8'd0;
			end
			v_s3 <= 1'b0;
		end else if (advance) begin
			v_s3 <= v_s2;
			if (v_s2) begin
				swin_q[0] <= swin_q[3];
				swin_q[1] <= swin_q[4];
				swin_q[2] <= swin_q[5];
				swin_q[3] <= sk_rd[15:8];
				swin_q[4] <= sk_rd[7:0];
				swin_q[5] <= mv_s2;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			bsum_s3   <= bsum2;
			inner2_s3 <= inner2_s2;
			last_s3   <= last_s2;
			emit_s3   <= emit_s2;
			old_s3    <= old_s2;
		end
	end

	// Stage 3: divide by twelve and select the output pixel.
	logic [23:0] bprod3;
	logic [7:0]  blur3;
	logic [7:0]  out_red_q;
	logic [7:0]  out_green_q;
	logic [7:0]  out_blue_q;
	logic        frame_last_q;

	assign bprod3 = 24'(bsum_s3) * 24'(RECIP12);
	assign blur3  = bprod3[SHIFT12+7:SHIFT12];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= v_s3 && emit_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			if (inner2_s3) begin
				out_red_q   <= blur3;
				out_green_q <= blur3;
				out_blue_q  <= blur3;
			end else begin
				out_red_q   <= old_s3[23:16];
				out_green_q <= old_s3[15:8];
				out_blue_q  <= old_s3[7:0];
			end
			frame_last_q <= last_s3;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_red    = out_red_q;
	assign out_green  = out_green_q;
	assign out_blue   = out_blue_q;
	assign frame_last = frame_last_q;

endmodule
